// ----- rtl/core/encoder_speed_sampler_assert.svh -----
// assertion macros shared by the encoder speed sampler rtl
`ifndef ENCODER_SPEED_SAMPLER_ASSERT_SVH
`define ENCODER_SPEED_SAMPLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ESP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ESP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/esp_pkg.sv -----
// shared types and constants of the encoder speed sampler
`timescale 1ns / 1ps

package esp_pkg;

    localparam int CNT_W   = 32;
    localparam int TIME_W  = 32;
    localparam int DELTA_W = 32;
    localparam int TOTAL_W = 64;
    localparam int SPEED_W = 42;
    localparam int MRPM_W  = 32;

    // magnitude of any counts-per-second value, |delta|*1000 also fits
    localparam int MAG_W  = 41;
    localparam int K_W    = 16;
    localparam int PROD_W = MAG_W + K_W;

    localparam int DIV_N_W    = PROD_W;
    localparam int DIV_D_W    = 32;
    localparam int DIV_STEP_W = $clog2(DIV_N_W + 1);

    localparam logic [K_W-1:0] K_CPS = K_W'(1000);
    localparam logic [K_W-1:0] K_RPM = K_W'(60000);

    localparam logic [DIV_STEP_W-1:0] STEPS_CPS = DIV_STEP_W'(MAG_W);
    localparam logic [DIV_STEP_W-1:0] STEPS_RPM = DIV_STEP_W'(DIV_N_W);

    localparam logic [DIV_N_W-1:0] MRPM_POS_MAX = DIV_N_W'(32'h7FFF_FFFF);
    localparam logic [DIV_N_W-1:0] MRPM_NEG_MAX = DIV_N_W'(32'h8000_0000);

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_MODE   = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_PERIOD = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_CPR    = 4'h8;

    localparam logic              RST_MODE   = 1'b0;
    localparam logic [TIME_W-1:0] RST_PERIOD = TIME_W'(10);
    localparam logic [DIV_D_W-1:0] RST_CPR   = DIV_D_W'(1024);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_CPS,
        ST_DIV_CPS,
        ST_WAIT_CPS,
        ST_MUL_RPM,
        ST_DIV_RPM,
        ST_WAIT_RPM,
        ST_DONE
    } t_esp_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
        logic [DIV_N_W-1:0]    dividend;
        logic [DIV_D_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ----- rtl/core/esp_if.sv -----
// request and result channel interfaces of the encoder speed sampler
`timescale 1ns / 1ps

interface esp_in_if;
    import esp_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [CNT_W-1:0]  cnt_value;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, opcode, cnt_value, now_ms, input ready);
    modport sink   (input valid, opcode, cnt_value, now_ms, output ready);
endinterface

interface esp_out_if;
    import esp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic signed [DELTA_W-1:0] delta_out;
    logic signed [TOTAL_W-1:0] total_out;
    logic signed [SPEED_W-1:0] speed_cps;
    logic signed [MRPM_W-1:0]  speed_millirpm;
    logic                      millirpm_valid;

    modport source (output valid, accepted, delta_out, total_out, speed_cps,
                    speed_millirpm, millirpm_valid, input ready);
    modport sink   (input valid, accepted, delta_out, total_out, speed_cps,
                    speed_millirpm, millirpm_valid, output ready);
endinterface

// ----- rtl/core/esp_div.sv -----
// restoring divider, one quotient bit per cycle, quotient and remainder out
`timescale 1ns / 1ps
`include "encoder_speed_sampler_assert.svh"

module esp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esp_pkg::t_div_req i_req,
    output esp_pkg::t_div_rsp o_rsp
);
    import esp_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_STEP_W-1:0] r_cnt, n_cnt;
    logic [DIV_D_W-1:0]    r_rem, n_rem;
    logic [DIV_N_W-1:0]    r_quo, n_quo;
    logic [DIV_D_W-1:0]    r_den, n_den;

    logic [DIV_D_W:0]   partial;
    logic [DIV_D_W+1:0] diff;
    logic               ge;

    assign partial = {r_rem, r_quo[DIV_N_W-1]};
    assign diff    = {1'b0, partial} - {2'b0, r_den};
    assign ge      = !diff[DIV_D_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DIV_D_W-1:0] : partial[DIV_D_W-1:0];
            n_quo = {r_quo[DIV_N_W-2:0], ge};
            n_cnt = r_cnt - DIV_STEP_W'(1);
            if (r_cnt == DIV_STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    `ESP_ASSERT_NOW(a_done_after_run, i_clk, i_rst_n, r_done, !r_busy && $past(r_busy),
        "divider done without a preceding run")
    `ESP_ASSERT_NOW(a_rem_below_den, i_clk, i_rst_n, r_done, r_rem < r_den,
        "divider remainder not below divisor")
    `ESP_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n,
        r_busy && !i_req.start && r_cnt == DIV_STEP_W'(1), r_done,
        "divider missed its done pulse")

endmodule

// ----- rtl/core/encoder_speed_sampler.sv -----
// top level of the encoder speed sampler: register port, sequencer, datapath
`timescale 1ns / 1ps
`include "encoder_speed_sampler_assert.svh"

// Encoder speed sampler. Each request is a start (latch counter and time,
// clear totals) or a sample (wrap-aware count delta, 64-bit running total,
// counts per second = delta*1000/elapsed, then milli-RPM from counts_per_rev),
// and every request gives exactly one result. All arithmetic runs through one
// 41x16 multiplier and one restoring divider that yields one quotient bit per
// cycle. A taken sample runs a divide of 41 steps for the speed and one of 57
// steps for milli-RPM; a start or an untaken sample runs only the milli-RPM
// divide. With counts_per_rev at zero the milli-RPM divide is skipped. One
// request is in flight at a time; a finished result sits in an output
// register so the next request can be taken while it waits, and a result
// still waiting there when the next one finishes holds the sequencer until
// the output is taken. Configuration registers sit at byte addresses 0x0
// (counter width mode), 0x4 (sample period) and 0x8 (counts per revolution);
// they must be written only while idle, which the block itself does not
// enforce.
module encoder_speed_sampler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [esp_pkg::ADDR_W-1:0]   paddr,
    input  logic [esp_pkg::DATA_W-1:0]   pwdata,
    output logic [esp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    esp_in_if.sink                       i_in,
    esp_out_if.source                    o_out
);
    import esp_pkg::*;

    // configuration
    logic               r_mode;
    logic [TIME_W-1:0]  r_period;
    logic [DIV_D_W-1:0] r_cpr;

    // measurement state
    t_esp_state         r_state, n_state;
    logic               r_init, n_init;
    logic [CNT_W-1:0]   r_prev, n_prev;
    logic [TIME_W-1:0]  r_last, n_last;
    logic [DELTA_W-1:0] r_held_delta, n_held_delta;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [SPEED_W-1:0] r_held_speed, n_held_speed;

    // per-request working registers
    logic               r_accepted, n_accepted;
    logic [TIME_W-1:0]  r_elapsed, n_elapsed;
    logic               r_neg, n_neg;
    logic [MAG_W-1:0]   r_mag, n_mag;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [MRPM_W-1:0]  r_mrpm, n_mrpm;
    logic               r_mrpm_ok, n_mrpm_ok;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_o_accepted;
    logic [DELTA_W-1:0] r_o_delta;
    logic [TOTAL_W-1:0] r_o_total;
    logic [SPEED_W-1:0] r_o_speed;
    logic [MRPM_W-1:0]  r_o_mrpm;
    logic               r_o_mrpm_ok;
    logic               out_load;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               cfg_wr;
    logic [CNT_W-1:0]   norm;
    logic [CNT_W-1:0]   cnt_diff;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0] delta_abs;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  period;
    logic               take;
    logic [SPEED_W-1:0] speed_abs;
    logic [SPEED_W-1:0] speed_mag;
    logic [K_W-1:0]     mul_k;
    logic [PROD_W-1:0]  prod;
    logic [DIV_N_W-1:0] q2;
    logic               rem_zero;
    logic               mrpm_fits;

    // register port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr)
            ADDR_MODE:   prdata = {{(DATA_W-1){1'b0}}, r_mode};
            ADDR_PERIOD: prdata = r_period;
            ADDR_CPR:    prdata = r_cpr;
            default:     prdata = '0;
        endcase
    end

    // request-side arithmetic
    assign norm      = r_mode ? i_in.cnt_value : {16'b0, i_in.cnt_value[15:0]};
    assign cnt_diff  = norm - r_prev;
    assign delta     = r_mode ? cnt_diff : {{16{cnt_diff[15]}}, cnt_diff[15:0]};
    assign delta_abs = delta[DELTA_W-1] ? (~delta + DELTA_W'(1)) : delta;
    assign elapsed   = i_in.now_ms - r_last;
    assign period    = (r_period == '0) ? TIME_W'(1) : r_period;
    assign take      = r_init && (elapsed >= period);
    assign speed_abs = r_held_speed[SPEED_W-1] ? (~r_held_speed + SPEED_W'(1))
                                               : r_held_speed;

    // shared multiplier
    assign mul_k = (r_state == ST_MUL_RPM) ? K_RPM : K_CPS;
    assign prod  = {{K_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, mul_k};

    assign speed_mag = {1'b0, div_rsp.quotient[MAG_W-1:0]};

    // fits when |cps|*60000 <= limit*cpr, read off quotient and remainder
    assign q2        = div_rsp.quotient;
    assign rem_zero  = (div_rsp.remainder == '0);
    assign mrpm_fits = r_neg ? ((q2 < MRPM_NEG_MAX) || (q2 == MRPM_NEG_MAX && rem_zero))
                             : ((q2 < MRPM_POS_MAX) || (q2 == MRPM_POS_MAX && rem_zero));

    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_init       = r_init;
        n_prev       = r_prev;
        n_last       = r_last;
        n_held_delta = r_held_delta;
        n_total      = r_total;
        n_held_speed = r_held_speed;
        n_accepted   = r_accepted;
        n_elapsed    = r_elapsed;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_prod       = r_prod;
        n_mrpm       = r_mrpm;
        n_mrpm_ok    = r_mrpm_ok;
        out_load     = 1'b0;
        div_req      = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.opcode == OP_START) begin
                        n_prev       = norm;
                        n_last       = i_in.now_ms;
                        n_held_delta = '0;
                        n_total      = '0;
                        n_held_speed = '0;
                        n_init       = 1'b1;
                        n_accepted   = 1'b1;
                        n_neg        = 1'b0;
                        n_mag        = '0;
                        n_state      = ST_MUL_RPM;
                    end else if (take) begin
                        n_prev       = norm;
                        n_last       = i_in.now_ms;
                        n_held_delta = delta;
                        n_total      = r_total + {{(TOTAL_W-DELTA_W){delta[DELTA_W-1]}}, delta};
                        n_elapsed    = elapsed;
                        n_accepted   = 1'b1;
                        n_neg        = delta[DELTA_W-1];
                        n_mag        = {{(MAG_W-DELTA_W){1'b0}}, delta_abs};
                        n_state      = ST_MUL_CPS;
                    end else begin
                        // not taken: only the milli-rpm of the held speed is redone
                        n_accepted = 1'b0;
                        n_neg      = r_held_speed[SPEED_W-1];
                        n_mag      = speed_abs[MAG_W-1:0];
                        n_state    = ST_MUL_RPM;
                    end
                end
            end
            ST_MUL_CPS: begin
                n_prod  = prod;
                n_state = ST_DIV_CPS;
            end
            ST_DIV_CPS: begin
                // |delta|*1000 fits MAG_W bits: align it to the top of the dividend
                div_req.start    = 1'b1;
                div_req.steps    = STEPS_CPS;
                div_req.dividend = r_prod << (DIV_N_W - MAG_W);
                div_req.divisor  = r_elapsed;
                n_state          = ST_WAIT_CPS;
            end
            ST_WAIT_CPS: begin
                if (div_rsp.done) begin
                    n_held_speed = r_neg ? (~speed_mag + SPEED_W'(1)) : speed_mag;
                    n_mag        = div_rsp.quotient[MAG_W-1:0];
                    n_state      = ST_MUL_RPM;
                end
            end
            ST_MUL_RPM: begin
                n_prod = prod;
                if (r_cpr == '0) begin
                    n_mrpm    = '0;
                    n_mrpm_ok = 1'b0;
                    n_state   = ST_DONE;
                end else begin
                    n_state = ST_DIV_RPM;
                end
            end
            ST_DIV_RPM: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEPS_RPM;
                div_req.dividend = r_prod;
                div_req.divisor  = r_cpr;
                n_state          = ST_WAIT_RPM;
            end
            ST_WAIT_RPM: begin
                if (div_rsp.done) begin
                    n_mrpm_ok = mrpm_fits;
                    if (!mrpm_fits) begin
                        n_mrpm = '0;
                    end else if (r_neg) begin
                        n_mrpm = ~q2[MRPM_W-1:0] + MRPM_W'(1);
                    end else begin
                        n_mrpm = q2[MRPM_W-1:0];
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= RST_MODE;
            r_period     <= RST_PERIOD;
            r_cpr        <= RST_CPR;
            r_state      <= ST_IDLE;
            r_init       <= 1'b0;
            r_prev       <= '0;
            r_last       <= '0;
            r_held_delta <= '0;
            r_total      <= '0;
            r_held_speed <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr)
                    ADDR_MODE:   r_mode   <= pwdata[0];
                    ADDR_PERIOD: r_period <= pwdata;
                    ADDR_CPR:    r_cpr    <= pwdata;
                    default:     ;
                endcase
            end
            r_state      <= n_state;
            r_init       <= n_init;
            r_prev       <= n_prev;
            r_last       <= n_last;
            r_held_delta <= n_held_delta;
            r_total      <= n_total;
            r_held_speed <= n_held_speed;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted <= n_accepted;
        r_elapsed  <= n_elapsed;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_prod     <= n_prod;
        r_mrpm     <= n_mrpm;
        r_mrpm_ok  <= n_mrpm_ok;
        if (out_load) begin
            r_o_accepted <= r_accepted;
            r_o_delta    <= r_held_delta;
            r_o_total    <= r_total;
            r_o_speed    <= r_held_speed;
            r_o_mrpm     <= r_mrpm;
            r_o_mrpm_ok  <= r_mrpm_ok;
        end
    end

    esp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.accepted       = r_o_accepted;
    assign o_out.delta_out      = r_o_delta;
    assign o_out.total_out      = r_o_total;
    assign o_out.speed_cps      = r_o_speed;
    assign o_out.speed_millirpm = r_o_mrpm;
    assign o_out.millirpm_valid = r_o_mrpm_ok;

    `ESP_ASSERT_NEXT(a_request_starts_work, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_state == ST_MUL_CPS || r_state == ST_MUL_RPM,
        "accepted request did not start the sequencer")
    `ESP_ASSERT_NEXT(a_start_arms, i_clk, i_rst_n,
        i_in.valid && i_in.ready && i_in.opcode == OP_START, r_init && r_accepted,
        "start request did not arm the block")
    `ESP_ASSERT_NOW(a_mrpm_zero_when_invalid, i_clk, i_rst_n,
        r_out_valid && !r_o_mrpm_ok, r_o_mrpm == '0,
        "milli-rpm not zero while flagged invalid")

endmodule
